FILE: rtl/kbd_pkg.sv
package kbd_pkg;

  // field widths of the keyboard channel
  localparam int KeyW      = 8;
  localparam int CharW     = 8;
  localparam int WordW     = 32;
  localparam int OpW       = 3;
  localparam int CharShift = 8;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OpKeypress = 3'd0,
    OpReadKey  = 3'd1,
    OpSetState = 3'd2,
    OpQuery    = 3'd3,
    OpClear    = 3'd4
  } op_e;

  // control sequencer states
  typedef enum logic {
    StIdle,
    StExec
  } state_e;

  // fifo commit controls
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctrl_t;

  // key state commit controls
  typedef struct packed {
    logic set_mods;
    logic set_held;
    logic clear;
  } keymap_ctrl_t;

endpackage

FILE: rtl/keyboard_event_fifo_and_key_state.sv
// Keyboard event queue with pressed-key tracking.
// Input channel (in_valid_i / in_ready_o) carries one operation per transfer:
// keypress, read key, set key state, query key or clear. Output channel
// (out_valid_o / out_ready_i) returns exactly one result per operation, in order:
// the popped word for a read, the fifo nonempty flag after the operation,
// the query match and the dropped flag of a keypress into a full fifo.
// The synchronous reads of the word memory and the pressed-key memory happen
// at the transfer edge; the modify, write back and output load happen at the
// commit edge, once the output register is free.
// One operation is in flight at a time, set by the read-then-commit sequence
// on the memories: no new input is taken until it commits; the next input is
// taken while a result still sits in the output register.
// If the receiver stalls, a finished operation waits in its commit cycle
// until the output register frees up, and no new input is taken meanwhile.
// Reset clears the pointers, full flag, modifier register, pressed-key marks
// and output valid; the word memory contents stay undefined until written.
module keyboard_event_fifo_and_key_state
  import kbd_pkg::*;
#(
  parameter int FIFO_DEPTH   = 16,
  parameter int OVERRUN_CODE = 255,
  parameter int UNKNOWN_CODE = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [KeyW-1:0]  key_i,
  input  logic [WordW-1:0] modifiers_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             is_down_i,
  input  logic [WordW-1:0] mod_on_i,
  input  logic [WordW-1:0] mod_off_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] read_word_o,
  output logic             have_key_o,
  output logic             match_o,
  output logic             dropped_o
);

  localparam logic [KeyW-1:0] OverrunKey = KeyW'(OVERRUN_CODE);
  localparam logic [KeyW-1:0] UnknownKey = KeyW'(UNKNOWN_CODE);

  state_e           state_q, state_d;
  logic             accept, commit, out_free;

  logic [OpW-1:0]   op_q;
  logic [KeyW-1:0]  key_q;
  logic [WordW-1:0] mods_q;
  logic [CharW-1:0] char_q;
  logic             down_q;
  logic [WordW-1:0] mon_q;
  logic [WordW-1:0] moff_q;

  fifo_ctrl_t       fifo_ctrl;
  keymap_ctrl_t     km_ctrl;
  logic [WordW-1:0] fifo_wdata, fifo_rdata;
  logic             fifo_full, fifo_nonempty, fifo_have_key;
  logic             held;
  logic [WordW-1:0] cur_mods;
  logic             key_in_map;

  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] read_word_q, read_word_d;
  logic             have_key_q, match_q, match_d, dropped_q, dropped_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      StIdle:  in_ready_o = 1'b1;
      StExec:  commit     = out_free;
      default: ;
    endcase
  end

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // capture operation at transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_i;
      key_q  <= key_i;
      mods_q <= modifiers_i;
      char_q <= char_code_i;
      down_q <= is_down_i;
      mon_q  <= mod_on_i;
      moff_q <= mod_off_i;
    end
  end

  assign key_in_map = (key_q < OverrunKey);
  assign fifo_wdata = WordW'(key_q) | mods_q | (WordW'(char_q) << CharShift);

  // commit decode and result values
  always_comb begin
    fifo_ctrl   = '0;
    km_ctrl     = '0;
    read_word_d = WordW'(UnknownKey);
    match_d     = 1'b0;
    dropped_d   = 1'b0;
    case (op_e'(op_q))
      OpKeypress: begin
        if (key_q != OverrunKey) begin
          if (fifo_full) begin
            dropped_d = 1'b1;
          end else begin
            fifo_ctrl.push = commit;
          end
        end
      end
      OpReadKey: begin
        if (fifo_nonempty) begin
          read_word_d   = fifo_rdata;
          fifo_ctrl.pop = commit;
        end
      end
      OpSetState: begin
        km_ctrl.set_mods = commit;
        km_ctrl.set_held = commit & (key_q != UnknownKey) & key_in_map;
      end
      OpQuery: begin
        match_d = key_in_map & ((cur_mods & mon_q) == mon_q) &
                  ((cur_mods & moff_q) == '0) & held;
      end
      OpClear: begin
        fifo_ctrl.clear = commit;
        km_ctrl.clear   = commit;
      end
      default: ;
    endcase
  end

  kbd_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .rd_en_i   (accept),
    .ctrl_i    (fifo_ctrl),
    .wdata_i   (fifo_wdata),
    .rdata_o   (fifo_rdata),
    .full_o    (fifo_full),
    .nonempty_o(fifo_nonempty),
    .have_key_o(fifo_have_key)
  );

  kbd_keymap #(
    .Depth(OVERRUN_CODE)
  ) u_keymap (
    .clk_i,
    .rst_ni,
    .rd_en_i  (accept & (key_i < OverrunKey)),
    .rd_key_i (key_i),
    .ctrl_i   (km_ctrl),
    .wr_key_i (key_q),
    .wr_down_i(down_q),
    .mods_i   (mods_q),
    .held_o   (held),
    .mods_o   (cur_mods)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      read_word_q <= read_word_d;
      have_key_q  <= fifo_have_key;
      match_q     <= match_d;
      dropped_q   <= dropped_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_word_o = read_word_q;
  assign have_key_o  = have_key_q;
  assign match_o     = match_q;
  assign dropped_o   = dropped_q;

endmodule

FILE: rtl/kbd_fifo.sv
module kbd_fifo
  import kbd_pkg::*;
#(
  parameter int Depth = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  fifo_ctrl_t       ctrl_i,
  input  logic [WordW-1:0] wdata_i,
  output logic [WordW-1:0] rdata_o,
  output logic             full_o,
  output logic             nonempty_o,
  output logic             have_key_o
);

  localparam int PtrW = $clog2(Depth);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic             full_q, full_d;
  logic [PtrW-1:0]  wptr_adv, rptr_adv;

  // ring pointer increment with wrap
  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign wptr_adv = advance(wptr_q);
  assign rptr_adv = advance(rptr_q);

  // pointer and full flag update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    full_d = full_q;
    if (ctrl_i.clear) begin
      wptr_d = '0;
      rptr_d = '0;
      full_d = 1'b0;
    end else if (ctrl_i.push) begin
      wptr_d = wptr_adv;
      full_d = (wptr_adv == rptr_q);
    end else if (ctrl_i.pop) begin
      rptr_d = rptr_adv;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      full_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      full_q <= full_d;
    end
  end

  // word storage, write at commit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  // head read, issued at input transfer
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rptr_q];
    end
  end

  assign rdata_o    = rdata_q;
  assign full_o     = full_q;
  assign nonempty_o = full_q | (wptr_q != rptr_q);
  assign have_key_o = full_d | (wptr_d != rptr_d);

endmodule

FILE: rtl/kbd_keymap.sv
module kbd_keymap
  import kbd_pkg::*;
#(
  parameter int Depth = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [KeyW-1:0]  rd_key_i,
  input  keymap_ctrl_t     ctrl_i,
  input  logic [KeyW-1:0]  wr_key_i,
  input  logic             wr_down_i,
  input  logic [WordW-1:0] mods_i,
  output logic             held_o,
  output logic [WordW-1:0] mods_o
);

  localparam int AddrW = $clog2(Depth);

  logic             mem [Depth];
  logic [Depth-1:0] vld_q, vld_d;
  logic             ram_q;
  logic             vld_rd_q;
  logic [WordW-1:0] mods_q, mods_d;
  logic [AddrW-1:0] rd_addr, wr_addr;

  assign rd_addr = rd_key_i[AddrW-1:0];
  assign wr_addr = wr_key_i[AddrW-1:0];

  // written marks, entries not marked read as released
  always_comb begin
    vld_d = vld_q;
    if (ctrl_i.clear) begin
      vld_d = '0;
    end else if (ctrl_i.set_held) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  // modifier register
  always_comb begin
    mods_d = mods_q;
    if (ctrl_i.clear) begin
      mods_d = '0;
    end else if (ctrl_i.set_mods) begin
      mods_d = mods_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      mods_q <= '0;
    end else begin
      vld_q  <= vld_d;
      mods_q <= mods_d;
    end
  end

  // pressed bit storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.set_held) begin
      mem[wr_addr] <= wr_down_i;
    end
  end

  // registered lookup of one key
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ram_q    <= mem[rd_addr];
      vld_rd_q <= vld_q[rd_addr];
    end
  end

  assign held_o = ram_q & vld_rd_q;
  assign mods_o = mods_q;

endmodule

FILE: sim/keyboard_event_fifo_and_key_state_tb.sv
module keyboard_event_fifo_and_key_state_tb
  import kbd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // block configuration, mirrored by the predictor
  localparam int FifoDepth   = 16;
  localparam int OverrunCode = 255;
  localparam int UnknownCode = 0;

  // op codes the block does not decode
  localparam int OpSpareLo = int'(OpClear) + 1;
  localparam int OpSpareHi = (1 << OpW) - 1;

  // key codes used for held-key tracking so that queries often hit
  localparam int PoolLo = 1;
  localparam int PoolHi = 8;

  localparam int RandomItems = 608;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 500000;
  localparam int MaxReported = 10;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [KeyW-1:0]  key;
    logic [WordW-1:0] modifiers;
    logic [CharW-1:0] char_code;
    logic             is_down;
    logic [WordW-1:0] mod_on;
    logic [WordW-1:0] mod_off;
  } kbd_cmd_t;

  typedef struct packed {
    logic [WordW-1:0] read_word;
    logic             have_key;
    logic             match;
    logic             dropped;
  } kbd_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OpW-1:0]   op;
  logic [KeyW-1:0]  key;
  logic [WordW-1:0] modifiers;
  logic [CharW-1:0] char_code;
  logic             is_down;
  logic [WordW-1:0] mod_on;
  logic [WordW-1:0] mod_off;
  logic             out_valid;
  logic             out_ready;
  logic [WordW-1:0] read_word;
  logic             have_key;
  logic             match;
  logic             dropped;

  // predicted state of the event queue and key tracking
  logic [WordW-1:0] queue_words [FifoDepth];
  int               queue_wr;
  int               queue_rd;
  logic             queue_full;
  logic [WordW-1:0] held_mods;
  logic             key_held [256];

  kbd_result_t      pending_results [$];
  int               items_sent;
  int               mismatches;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               cycle_count;

  keyboard_event_fifo_and_key_state #(
    .FIFO_DEPTH  (FifoDepth),
    .OVERRUN_CODE(OverrunCode),
    .UNKNOWN_CODE(UnknownCode)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .op_i       (op),
    .key_i      (key),
    .modifiers_i(modifiers),
    .char_code_i(char_code),
    .is_down_i  (is_down),
    .mod_on_i   (mod_on),
    .mod_off_i  (mod_off),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .read_word_o(read_word),
    .have_key_o (have_key),
    .match_o    (match),
    .dropped_o  (dropped)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // expected result of one operation, advancing the predicted state
  function automatic kbd_result_t kbd_outcome(input kbd_cmd_t c);
    kbd_result_t r;
    r.read_word = WordW'(UnknownCode);
    r.match     = 1'b0;
    r.dropped   = 1'b0;
    case (c.op)
      OpKeypress: begin
        if (int'(c.key) != OverrunCode) begin
          if (queue_full) begin
            r.dropped = 1'b1;
          end else begin
            queue_words[queue_wr] = WordW'(c.key) | c.modifiers |
                                    (WordW'(c.char_code) << CharShift);
            queue_wr = (queue_wr + 1) % FifoDepth;
            if (queue_wr == queue_rd) begin
              queue_full = 1'b1;
            end
          end
        end
      end
      OpReadKey: begin
        if (queue_full || queue_wr != queue_rd) begin
          r.read_word = queue_words[queue_rd];
          queue_rd    = (queue_rd + 1) % FifoDepth;
          queue_full  = 1'b0;
        end
      end
      OpSetState: begin
        held_mods = c.modifiers;
        if (int'(c.key) != UnknownCode && int'(c.key) < OverrunCode) begin
          key_held[c.key] = c.is_down;
        end
      end
      OpQuery: begin
        r.match = (int'(c.key) < OverrunCode) &&
                  ((held_mods & c.mod_on) == c.mod_on) &&
                  ((held_mods & c.mod_off) == '0) && key_held[c.key];
      end
      OpClear: begin
        queue_full = 1'b0;
        queue_wr   = 0;
        queue_rd   = 0;
        held_mods  = '0;
        foreach (key_held[i]) key_held[i] = 1'b0;
      end
      default: begin
      end
    endcase
    r.have_key = queue_full || (queue_wr != queue_rd);
    return r;
  endfunction

  function automatic kbd_cmd_t make_cmd(input int o, input int k, input logic [WordW-1:0] m,
                                        input int ch, input bit d,
                                        input logic [WordW-1:0] on,
                                        input logic [WordW-1:0] off);
    kbd_cmd_t c;
    c.op        = OpW'(o);
    c.key       = KeyW'(k);
    c.modifiers = m;
    c.char_code = CharW'(ch);
    c.is_down   = d;
    c.mod_on    = on;
    c.mod_off   = off;
    return c;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_op(input kbd_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= c.op;
    key       <= c.key;
    modifiers <= c.modifiers;
    char_code <= c.char_code;
    is_down   <= c.is_down;
    mod_on    <= c.mod_on;
    mod_off   <= c.mod_off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(kbd_outcome(c));
    items_sent++;
  endtask

  task automatic note_mismatch(input string field, input logic [WordW-1:0] want,
                               input logic [WordW-1:0] got);
    mismatches++;
    if (mismatches <= MaxReported) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    kbd_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("%0t: result with nothing expected, word %h", $realtime, read_word);
        end
      end else begin
        want = pending_results.pop_front();
        if (read_word !== want.read_word) note_mismatch("read_word", want.read_word, read_word);
        if (have_key !== want.have_key) note_mismatch("have_key", want.have_key, have_key);
        if (match !== want.match) note_mismatch("match", want.match, match);
        if (dropped !== want.dropped) note_mismatch("dropped", want.dropped, dropped);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // empty reads, overrun keys, packing extremes and queue order
  task automatic test_event_queue();
    send_op(make_cmd(OpReadKey, 0, '0, 0, 1'b0, '0, '0));
    send_op(make_cmd(OpKeypress, OverrunCode, '1, 8'hff, 1'b1, '0, '0));
    send_op(make_cmd(OpKeypress, OverrunCode - 1, '0, 8'hff, 1'b0, '0, '0));
    send_op(make_cmd(OpKeypress, 1, 32'hffff_0000, 0, 1'b0, '1, '1));
    send_op(make_cmd(OpKeypress, UnknownCode, '0, 8'h80, 1'b1, '0, '0));
    repeat (4) send_op(make_cmd(OpReadKey, 8'h5a, '1, 8'h5a, 1'b1, '1, '1));
  endtask

  // modifier register, held bitmap and invalid codes
  task automatic test_key_state();
    send_op(make_cmd(OpSetState, UnknownCode, '1, 0, 1'b1, '0, '0));
    send_op(make_cmd(OpQuery, UnknownCode, '0, 0, 1'b0, '0, '0));
    send_op(make_cmd(OpSetState, OverrunCode, 32'ha5a5_a5a5, 0, 1'b1, '0, '0));
    send_op(make_cmd(OpQuery, OverrunCode, '0, 0, 1'b0, '0, '0));
    send_op(make_cmd(OpSetState, OverrunCode - 1, '1, 0, 1'b1, '0, '0));
    send_op(make_cmd(OpQuery, OverrunCode - 1, '0, 0, 1'b0, '1, '0));
    send_op(make_cmd(OpQuery, OverrunCode - 1, '0, 0, 1'b0, '0, 32'h1));
    send_op(make_cmd(OpSetState, 1, 32'h1, 0, 1'b1, '0, '0));
    send_op(make_cmd(OpQuery, 1, '0, 0, 1'b0, 32'h1, 32'hffff_fffe));
    send_op(make_cmd(OpSetState, 1, 32'h1, 0, 1'b0, '0, '0));
    send_op(make_cmd(OpQuery, 1, '0, 0, 1'b0, 32'h1, '0));
  endtask

  // undecoded ops change nothing, clear drops queue and key state
  task automatic test_spare_ops_and_clear();
    int o;
    send_op(make_cmd(OpKeypress, 8'h3c, 32'h0100_0000, 8'h41, 1'b1, '0, '0));
    for (o = OpSpareLo; o <= OpSpareHi; o++) begin
      send_op(make_cmd(o, 8'hff, '1, 8'hff, 1'b1, '1, '1));
    end
    send_op(make_cmd(OpClear, 8'hff, '1, 8'hff, 1'b1, '1, '1));
    send_op(make_cmd(OpQuery, OverrunCode - 1, '0, 0, 1'b0, '0, '0));
  endtask

  // random traffic: mostly plausible keyboard activity plus queue fill bursts
  task automatic test_random_traffic(input int count);
    int               target;
    int               pick;
    int               k;
    int               i;
    logic [WordW-1:0] m;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        // fill past full, then drain past empty
        for (i = 0; i < FifoDepth + 2; i++) begin
          send_op(make_cmd(OpKeypress, $urandom_range(OverrunCode - 1, 0), $urandom,
                           $urandom_range(255), $urandom_range(1), $urandom, $urandom));
        end
        for (i = 0; i < FifoDepth + 2; i++) begin
          send_op(make_cmd(OpReadKey, $urandom_range(255), $urandom, $urandom_range(255),
                           $urandom_range(1), $urandom, $urandom));
        end
      end else if (pick < 33) begin
        k = ($urandom_range(9) == 0) ? OverrunCode : $urandom_range(255);
        m = $urandom_range(1) ? $urandom : ($urandom & 32'hffff_0000);
        send_op(make_cmd(OpKeypress, k, m, $urandom_range(255), $urandom_range(1),
                         $urandom, $urandom));
      end else if (pick < 58) begin
        send_op(make_cmd(OpReadKey, $urandom_range(255), $urandom, $urandom_range(255),
                         $urandom_range(1), $urandom, $urandom));
      end else if (pick < 77) begin
        pick = $urandom_range(19);
        if (pick == 0) k = UnknownCode;
        else if (pick == 1) k = OverrunCode;
        else if (pick < 6) k = $urandom_range(255);
        else k = $urandom_range(PoolHi, PoolLo);
        send_op(make_cmd(OpSetState, k, $urandom, $urandom_range(255),
                         $urandom_range(3) != 0, $urandom, $urandom));
      end else if (pick < 96) begin
        k = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(PoolHi, PoolLo);
        if ($urandom_range(3) == 0) begin
          send_op(make_cmd(OpQuery, k, $urandom, $urandom_range(255), $urandom_range(1),
                           $urandom, $urandom));
        end else begin
          send_op(make_cmd(OpQuery, k, $urandom, $urandom_range(255), $urandom_range(1),
                           held_mods & $urandom, ~held_mods & $urandom));
        end
      end else if (pick < 98) begin
        send_op(make_cmd(OpClear, $urandom_range(255), $urandom, $urandom_range(255),
                         $urandom_range(1), $urandom, $urandom));
      end else begin
        send_op(make_cmd($urandom_range(OpSpareHi, OpSpareLo), $urandom_range(255), $urandom,
                         $urandom_range(255), $urandom_range(1), $urandom, $urandom));
      end
    end
  endtask

  // test sequence
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    op          <= OpClear;
    key         <= '0;
    modifiers   <= '0;
    char_code   <= '0;
    is_down     <= 1'b0;
    mod_on      <= '0;
    mod_off     <= '0;
    out_ready   <= 1'b0;
    items_sent  = 0;
    mismatches  = 0;
    queue_wr    = 0;
    queue_rd    = 0;
    queue_full  = 1'b0;
    held_mods   = '0;
    foreach (key_held[i]) key_held[i] = 1'b0;
    tx_idle_pct = 19;
    rx_idle_pct = 72;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_event_queue();
    test_key_state();
    test_spare_ops_and_clear();
    test_random_traffic(RandomItems);

    tx_idle_pct = 72;
    rx_idle_pct = 19;
    test_random_traffic(RandomItems);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(RandomItems);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
